// ===== rtl/drld_pkg.sv =====
// ----------------------------------------------------------------------------
// drld_pkg: shared types and constants
// Widths, character codes and the shared adder interface for the decimal
// run-length decoder.
// ----------------------------------------------------------------------------
package drld_pkg;

    localparam int MAX_RUN_DEF = 64;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 7;   // holds 0..64
    localparam int ACC_W       = 10;  // holds count * 10 + 9
    localparam int DIGIT_W     = 4;

    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

    typedef logic [ACC_W-1:0] t_acc;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        t_acc    a;
        t_acc    b;
    } t_alu_req;

    typedef struct packed {
        t_acc res;
        logic over;   // sum above MAX_RUN
    } t_alu_rsp;

endpackage

// ===== rtl/drld_alu.sv =====
// ----------------------------------------------------------------------------
// drld_alu: shared add/subtract unit
// One adder reused for the count build-up (x8 + x2, then + digit) and for
// counting down the bytes of a run; also flags a sum above MAX_RUN.
// ----------------------------------------------------------------------------
module drld_alu
    import drld_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    t_acc w_res;

    always_comb begin
        case (i_req.op)
            ALU_ADD: w_res = i_req.a + i_req.b;
            ALU_SUB: w_res = i_req.a - i_req.b;
            default: w_res = i_req.a;
        endcase
    end

    assign o_rsp.res  = w_res;
    assign o_rsp.over = (i_req.op == ALU_ADD) && (w_res > ACC_W'(MAX_RUN));

endmodule

// ===== rtl/decimal_run_length_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_run_length_decoder_unit: decimal run-length decoder
// Sequencer around one shared adder that turns a character followed by a
// decimal repeat count into a run of output bytes.
// ----------------------------------------------------------------------------
// Takes one compressed byte per input item. The first byte with no run pending
// is stored in the accept cycle and the block is ready again at once. A digit
// is accepted, then makes two passes through the shared adder (count * 8 +
// count * 2, then + digit with saturation at MAX_RUN). A byte that ends a
// run, or a flush item (tlast), is accepted and then the run is emitted, 1
// to MAX_RUN bytes (none for a flush with nothing pending), the adder
// counting the run down; a stall on the output side holds the emission. No
// new input is taken until the digit or run is done. Output items sit in a
// register, so the block keeps working while the last one waits.
module decimal_run_length_decoder_unit
    import drld_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,   // flush
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,   // run_end
    output logic              m_axis_tuser    // [0] count_clipped
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [BYTE_W-1:0]  r_char;
    logic               r_pending;
    logic [COUNT_W-1:0] r_count;
    logic               r_over;
    logic [DIGIT_W-1:0] r_digit;
    t_acc               r_acc;
    logic [BYTE_W-1:0]  r_next_char;
    logic               r_clear;
    logic [COUNT_W-1:0] r_remain;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic               r_out_clip;

    t_alu_req w_req;
    t_alu_rsp w_rsp;
    logic     w_in_acc;
    logic     w_is_digit;
    logic     w_slot_free;
    logic     w_emit;

    drld_alu #(
        .MAX_RUN(MAX_RUN)
    ) u_alu (
        .i_req(w_req),
        .o_rsp(w_rsp)
    );

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_is_digit  = (s_axis_tdata >= CHAR_ZERO) && (s_axis_tdata <= CHAR_NINE);
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_emit      = (r_state == ST_EMIT) && w_slot_free;

    always_comb begin
        case (r_state)
            ST_MUL: begin
                w_req.op = ALU_ADD;
                w_req.a  = ACC_W'({r_count, 3'b000});
                w_req.b  = ACC_W'({r_count, 1'b0});
            end
            ST_ADD: begin
                w_req.op = ALU_ADD;
                w_req.a  = r_acc;
                w_req.b  = ACC_W'(r_digit);
            end
            default: begin
                w_req.op = ALU_SUB;
                w_req.a  = ACC_W'(r_remain);
                w_req.b  = ACC_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_char      <= '0;
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_over      <= 1'b0;
            r_clear     <= 1'b0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_remain <= (r_count == '0) ? COUNT_W'(1) : r_count;
                        if (s_axis_tlast) begin
                            r_clear <= 1'b1;
                            if (r_pending) begin
                                r_state <= ST_EMIT;
                            end
                        end else if (!r_pending) begin
                            r_char    <= s_axis_tdata;
                            r_pending <= 1'b1;
                            r_count   <= '0;
                            r_over    <= 1'b0;
                        end else if (w_is_digit) begin
                            r_digit <= DIGIT_W'(s_axis_tdata - CHAR_ZERO);
                            r_state <= ST_MUL;
                        end else begin
                            r_next_char <= s_axis_tdata;
                            r_clear     <= 1'b0;
                            r_state     <= ST_EMIT;
                        end
                    end
                end
                ST_MUL: begin
                    r_acc   <= w_rsp.res;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    if (w_rsp.over) begin
                        r_count <= COUNT_W'(MAX_RUN);
                        r_over  <= 1'b1;
                    end else begin
                        r_count <= w_rsp.res[COUNT_W-1:0];
                    end
                    r_state <= ST_IDLE;
                end
                ST_EMIT: begin
                    if (w_slot_free) begin
                        r_out_byte  <= r_char;
                        r_out_last  <= (r_remain == COUNT_W'(1));
                        r_out_clip  <= r_over;
                        r_remain    <= w_rsp.res[COUNT_W-1:0];
                        if (r_remain == COUNT_W'(1)) begin
                            // run done: start the next one or clear on flush
                            r_count <= '0;
                            r_over  <= 1'b0;
                            r_state <= ST_IDLE;
                            if (r_clear) begin
                                r_char    <= '0;
                                r_pending <= 1'b0;
                            end else begin
                                r_char    <= r_next_char;
                                r_pending <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_clip;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_RUN))
        else $error("run count above MAX_RUN");

    a_over_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over |-> (r_count == COUNT_W'(MAX_RUN)))
        else $error("overflow flag without saturated count");

    a_emit_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_remain != '0) && r_pending)
        else $error("emitting with nothing left");

endmodule

// ===== bench/decimal_run_length_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_run_length_checker: scoreboard for the decimal run-length decoder
// Watches both stream channels. Each accepted input item updates its own copy
// of the decoder state and queues the run bytes that the item releases. Each
// accepted output item is compared field by field against the oldest queued
// byte.
// ----------------------------------------------------------------------------
module decimal_run_length_checker
    import drld_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_s_tlast,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [BYTE_W-1:0] i_m_tdata,
    input  logic              i_m_tlast,
    input  logic              i_m_tuser,
    output int                o_mismatch_count,
    output int                o_outstanding,
    output int                o_bytes_seen,
    output int                o_clipped_seen
);

    localparam int DECIMAL_BASE = 10;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_end;
        logic              clipped;
    } t_run_byte;

    t_run_byte run_bytes_due[$];

    // decoder state as seen from the stream
    logic [BYTE_W-1:0]  pend_char;
    logic               pend_valid;
    logic [COUNT_W-1:0] rep_count;
    logic               rep_over;

    int mismatches;
    int bytes_seen;
    int clipped_seen;

    task automatic queue_run();
        int        n;
        t_run_byte rb;
        n = (rep_count == '0) ? 1 : int'(rep_count);
        for (int k = 0; k < n; k++) begin
            rb.out_byte = pend_char;
            rb.run_end  = (k == n - 1);
            rb.clipped  = rep_over;
            run_bytes_due.push_back(rb);
        end
    endtask

    task automatic start_run(input logic [BYTE_W-1:0] ch);
        pend_char  = ch;
        pend_valid = 1'b1;
        rep_count  = '0;
        rep_over   = 1'b0;
    endtask

    task automatic decode_item(input logic [BYTE_W-1:0] b, input logic fl);
        int acc;
        if (fl) begin
            if (pend_valid) begin
                queue_run();
            end
            pend_char  = '0;
            pend_valid = 1'b0;
            rep_count  = '0;
            rep_over   = 1'b0;
        end else if (!pend_valid) begin
            start_run(b);
        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            acc = int'(rep_count) * DECIMAL_BASE + int'(b - CHAR_ZERO);
            // saturate and remember that the count was clipped
            if (acc > MAX_RUN) begin
                acc      = MAX_RUN;
                rep_over = 1'b1;
            end
            rep_count = COUNT_W'(acc);
        end else begin
            queue_run();
            start_run(b);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_run_byte want;
        if (!i_rst_n) begin
            pend_char    = '0;
            pend_valid   = 1'b0;
            rep_count    = '0;
            rep_over     = 1'b0;
            mismatches   = 0;
            bytes_seen   = 0;
            clipped_seen = 0;
            run_bytes_due.delete();
        end else begin
            // an output item can only come from an input accepted earlier
            if (i_m_tvalid && i_m_tready) begin
                bytes_seen++;
                if (i_m_tuser) begin
                    clipped_seen++;
                end
                if (run_bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT) begin
                        $display("[%0t] unexpected output item: byte %02h last %0b clipped %0b",
                                 $realtime, i_m_tdata, i_m_tlast, i_m_tuser);
                    end
                end else begin
                    want = run_bytes_due.pop_front();
                    if (want.out_byte !== i_m_tdata || want.run_end !== i_m_tlast ||
                        want.clipped !== i_m_tuser) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT) begin
                            $display({"[%0t] output item %0d: expected byte %02h last %0b ",
                                      "clipped %0b, got byte %02h last %0b clipped %0b"},
                                     $realtime, bytes_seen, want.out_byte, want.run_end,
                                     want.clipped, i_m_tdata, i_m_tlast, i_m_tuser);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_item(i_s_tdata, i_s_tlast);
            end
        end
        o_mismatch_count <= mismatches;
        o_outstanding    <= run_bytes_due.size();
        o_bytes_seen     <= bytes_seen;
        o_clipped_seen   <= clipped_seen;
    end

endmodule

// ===== bench/tb_decimal_run_length_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_run_length_decoder_unit: stimulus and verdict
// Drives a directed sequence of corner cases (flush with nothing pending,
// digit as run character, zero and saturated counts, digit boundaries), then
// random well-formed runs mixed with flushes and stray bytes, with random
// idling on both sides. Checking is done by decimal_run_length_checker.
// ----------------------------------------------------------------------------
module tb_decimal_run_length_decoder_unit;
    import drld_pkg::*;

    // the limit leaves room for the slowest correct run: ~430 items, each up to
    // 64 bytes with a stalling receiver
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = MAX_RUN_DEF + 16;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata  = '0;   // [7:0] data_byte
    logic              s_axis_tlast  = 1'b0; // flush
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [BYTE_W-1:0] m_axis_tdata;         // [7:0] out_byte
    logic              m_axis_tlast;         // run_end
    logic              m_axis_tuser;         // [0] count_clipped

    int mismatch_count;
    int outstanding;
    int bytes_seen;
    int clipped_seen;

    logic send_idles = 1'b1;
    logic recv_stalls = 1'b1;
    int   items_sent = 0;
    int   flushes_sent = 0;
    int   cycle_count = 0;

    decimal_run_length_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    decimal_run_length_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_s_tlast        (s_axis_tlast),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tlast        (m_axis_tlast),
        .i_m_tuser        (m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding),
        .o_bytes_seen     (bytes_seen),
        .o_clipped_seen   (clipped_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !recv_stalls || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d output items still due",
                     cycle_count, outstanding);
            $display("** decimal_run_length_decoder_unit: FAILED **");
            $finish;
        end
    end

    // hold the item until the block takes it; valid stays up between items unless idles are drawn
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic fl);
        while (send_idles && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fl;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (fl) begin
            flushes_sent++;
        end
    endtask

    task automatic send_digit(input int d);
        send_item(CHAR_ZERO + BYTE_W'(d), 1'b0);
    endtask

    task automatic send_flush();
        send_item(BYTE_W'($urandom_range(255)), 1'b1);
    endtask

    // drop valid and hold off until every due output item has arrived
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [BYTE_W-1:0] rand_nondigit();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
        return b;
    endfunction

    initial begin : stimulus
        int rand_items;
        int pick;
        int n_digits;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        send_item(8'hFF, 1'b1);          // flush with nothing pending
        send_digit(5);                   // digit becomes the run character
        send_digit(3);
        send_item(8'h00, 1'b0);          // '5' x3, 0x00 pending
        send_digit(0);
        send_digit(0);                   // zero count still emits once
        send_item(8'hFF, 1'b0);
        send_digit(6);
        send_digit(4);                   // exactly the maximum, not clipped
        send_item(8'h41, 1'b0);
        send_digit(6);
        send_digit(5);                   // one above the maximum
        send_item(8'h42, 1'b0);
        send_digit(9);
        send_digit(9);
        send_digit(9);                   // further digits keep it saturated
        send_item(CHAR_ZERO + 8'd7, 1'b1);
        send_item(8'h2F, 1'b1);          // second flush finds nothing pending
        send_digit(9);
        send_item(8'h2F, 1'b0);          // just below '0' ends the run
        send_digit(2);
        send_item(8'h3A, 1'b0);          // just above '9' ends the run
        send_digit(1);
        send_digit(0);
        send_flush();
        wait_results_drained();

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            // a stretch with no idling on either side
            send_idles  = !(rand_items >= 120 && rand_items < 220);
            recv_stalls = send_idles;
            if (rand_items >= 300 && rand_items < 305) begin
                wait_results_drained();
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_item(BYTE_W'($urandom_range(255)), 1'b0);
                rand_items++;
            end else if (pick < 14) begin
                send_flush();
                rand_items++;
            end else begin
                send_item(rand_nondigit(), 1'b0);
                rand_items++;
                pick = $urandom_range(99);
                if (pick < 40) begin
                    n_digits = 0;
                end else if (pick < 75) begin
                    send_digit($urandom_range(9));
                    n_digits = 1;
                end else if (pick < 88) begin
                    send_digit($urandom_range(5));
                    send_digit($urandom_range(9));
                    n_digits = 2;
                end else if (pick < 95) begin
                    send_digit(6);
                    send_digit($urandom_range(3, 5));
                    n_digits = 2;
                end else begin
                    n_digits = $urandom_range(3, 4);
                    repeat (n_digits) send_digit($urandom_range(9));
                end
                rand_items += n_digits;
            end
        end
        send_idles  = 1'b1;
        recv_stalls = 1'b1;
        send_flush();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items (%0d flushes); checked %0d decoded bytes, %0d from clipped runs",
                 items_sent, flushes_sent, bytes_seen, clipped_seen);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("** decimal_run_length_decoder_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d output items never arrived",
                     mismatch_count, outstanding);
            $display("** decimal_run_length_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
